### sv/btnclk_pkg.sv
// Shared types, state codes, event codes and register indexes for the button
// click and long-press detector. No dependencies.
`default_nettype none

package btnclk_pkg;

   // Width of the internal timestamp arithmetic.
   localparam int TIME_WIDTH = 32;
   // Elapsed-time comparisons are done at the wider of the time and register widths.
   localparam int CMP_WIDTH = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_DOWN     = 3'd1,
      ST_UP       = 3'd2,
      ST_COUNT    = 3'd3,
      ST_LONG     = 3'd4,
      ST_LONG_END = 3'd5
   } state_type;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_CLICK      = 3'd1;
   localparam logic [2:0] EV_DOUBLE     = 3'd2;
   localparam logic [2:0] EV_MULTI      = 3'd3;
   localparam logic [2:0] EV_LONG_START = 3'd4;
   localparam logic [2:0] EV_LONG_STOP  = 3'd5;

   localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
   localparam logic [1:0] REG_CLICK_WINDOW = 2'd2;
   localparam logic [1:0] REG_MAX_CLICKS   = 2'd3;

   localparam logic [3:0] CLICKS_MAX = 4'hF;

   typedef struct packed {
      logic        active_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [3:0] click_count;
      logic       debounced_level;
      logic       long_press_active;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] long_press_ms;
      logic [15:0] click_window_ms;
      logic [3:0]  max_clicks;
   } cfg_type;

   typedef struct packed {
      state_type               fsm;
      state_type               prev;
      logic [TIME_WIDTH-1:0]   start_time;
      logic [3:0]              clicks;
      logic                    debounced;
      logic                    long_active;
   } ctx_type;

endpackage

`default_nettype wire

### sv/btnclk_step.sv
// Next-state and result logic for one button sample.
// Depends on btnclk_pkg for the state, configuration and payload types.
`default_nettype none

module btnclk_step
   import btnclk_pkg::*;
(
   input  var ctx_type cur,
   input  var cfg_type cfg,
   input  var req_type sample,
   output ctx_type     nxt,
   output rsp_type     result
);

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] elapsed;
   logic [CMP_WIDTH-1:0]  elapsed_w;
   logic [CMP_WIDTH-1:0]  debounce_w;
   logic [CMP_WIDTH-1:0]  long_w;
   logic [CMP_WIDTH-1:0]  window_w;
   logic                  level;
   logic                  short_hold;
   logic [2:0]            ev;
   logic                  click_ev;

   assign now_t      = TIME_WIDTH'(sample.now_ms);
   assign elapsed    = now_t - cur.start_time;
   assign elapsed_w  = CMP_WIDTH'(elapsed);
   assign debounce_w = CMP_WIDTH'(cfg.debounce_ms);
   assign long_w     = CMP_WIDTH'(cfg.long_press_ms);
   assign window_w   = CMP_WIDTH'(cfg.click_window_ms);
   assign level      = sample.active_level;
   assign short_hold = elapsed_w < debounce_w;

   always_comb begin
      nxt = cur;
      ev  = EV_NONE;
      case (cur.fsm)
         ST_IDLE: begin
            if (level) begin
               nxt.prev       = cur.fsm;
               nxt.fsm        = ST_DOWN;
               nxt.start_time = now_t;
               nxt.clicks     = '0;
            end
         end
         ST_DOWN: begin
            if (!level) begin
               nxt.prev = cur.fsm;
               if (short_hold) begin
                  // A bounce returns to the state held before this one.
                  nxt.fsm = cur.prev;
               end else begin
                  nxt.fsm        = ST_UP;
                  nxt.debounced  = 1'b0;
                  nxt.start_time = now_t;
               end
            end else if (elapsed_w > long_w) begin
               ev              = EV_LONG_START;
               nxt.long_active = 1'b1;
               nxt.debounced   = 1'b1;
               nxt.prev        = cur.fsm;
               nxt.fsm         = ST_LONG;
            end
         end
         ST_UP: begin
            if (level && short_hold) begin
               nxt.prev = cur.fsm;
               nxt.fsm  = cur.prev;
            end else if (!short_hold) begin
               if (cur.clicks != CLICKS_MAX) begin
                  nxt.clicks = cur.clicks + 4'd1;
               end
               nxt.debounced = level;
               nxt.prev      = cur.fsm;
               nxt.fsm       = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (level) begin
               nxt.prev       = cur.fsm;
               nxt.fsm        = ST_DOWN;
               nxt.start_time = now_t;
            end else if ((elapsed_w > window_w) || (cur.clicks >= cfg.max_clicks)) begin
               if (cur.clicks == 4'd1) begin
                  ev = EV_CLICK;
               end else if (cur.clicks == 4'd2) begin
                  ev = EV_DOUBLE;
               end else begin
                  ev = EV_MULTI;
               end
            end
         end
         ST_LONG: begin
            if (!level) begin
               nxt.prev       = cur.fsm;
               nxt.fsm        = ST_LONG_END;
               nxt.start_time = now_t;
            end
         end
         ST_LONG_END: begin
            if (level && short_hold) begin
               nxt.prev = cur.fsm;
               nxt.fsm  = cur.prev;
            end else if (!short_hold) begin
               ev              = EV_LONG_STOP;
               nxt.long_active = 1'b0;
               nxt.fsm         = ST_IDLE;
               nxt.prev        = ST_IDLE;
               nxt.clicks      = '0;
               nxt.start_time  = '0;
            end
         end
         default: begin
            nxt.fsm        = ST_IDLE;
            nxt.prev       = ST_IDLE;
            nxt.clicks     = '0;
            nxt.start_time = '0;
         end
      endcase

      // The reported count is taken before a click report ends the gesture.
      result.event_res         = ev;
      result.click_count       = nxt.clicks;
      result.debounced_level   = nxt.debounced;
      result.long_press_active = nxt.long_active;

      click_ev = (ev == EV_CLICK) || (ev == EV_DOUBLE) || (ev == EV_MULTI);
      if (click_ev) begin
         nxt.fsm        = ST_IDLE;
         nxt.prev       = ST_IDLE;
         nxt.clicks     = '0;
         nxt.start_time = '0;
      end
   end

endmodule

`default_nettype wire

### sv/button_click_longpress_detector.sv
// Top level of the button click and long-press detector.
// Depends on btnclk_pkg and btnclk_step.
//
// Usage: each req transaction carries one button sample (level with polarity
// applied, and a millisecond timestamp). Each sample yields exactly one rsp
// transaction with an event code (none, click, double, multi, long start,
// long stop), the click count, the debounced level and the long-press flag.
// A sample is held in an input register, then the state machine, one
// subtractor and a few comparators produce the next state and the result,
// which lands in the output register. rsp_valid rises from the output
// register once the state update has moved the sample there from the input
// register; throughput is one sample per cycle while the receiver does not
// stall, set by the state update between the two registers.
// The csr port writes debounce, long-press, click-window and max-click
// registers; write only while no sample is in flight.
// Reset clears the state machine, the pipeline valids and restores the
// register defaults (50, 800, 400, 3). When the receiver stalls, the output
// register holds its transaction and the input register takes one more
// sample; req_ready then drops until the output drains.
`default_nettype none

module button_click_longpress_detector
   import btnclk_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  var req_type req_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   ctx_type ctx_ff, ctx_in;
   cfg_type cfg_ff, cfg_in;
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   ctx_type step_ctx;
   rsp_type step_rsp;
   logic    advance;
   logic    out_free;

   btnclk_step u_step (
      .cur    (ctx_ff),
      .cfg    (cfg_ff),
      .sample (s1_data_ff),
      .nxt    (step_ctx),
      .result (step_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DEBOUNCE:     cfg_in.debounce_ms     = csr_wdata;
            REG_LONG_PRESS:   cfg_in.long_press_ms   = csr_wdata;
            REG_CLICK_WINDOW: cfg_in.click_window_ms = csr_wdata;
            REG_MAX_CLICKS:   cfg_in.max_clicks      = csr_wdata[3:0];
            default:          cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ctx_in       = ctx_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (advance) begin
         ctx_in       = step_ctx;
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         ctx_ff.fsm             <= ST_IDLE;
         ctx_ff.prev            <= ST_IDLE;
         ctx_ff.start_time      <= '0;
         ctx_ff.clicks          <= '0;
         ctx_ff.debounced       <= 1'b0;
         ctx_ff.long_active     <= 1'b0;
         cfg_ff.debounce_ms     <= 16'd50;
         cfg_ff.long_press_ms   <= 16'd800;
         cfg_ff.click_window_ms <= 16'd400;
         cfg_ff.max_clicks      <= 4'd3;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctx_ff       <= ctx_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### sv/btnclk_checker.sv
// Port-level checks on the result channel of the detector, bound to the top.
// Depends on btnclk_pkg and button_click_longpress_detector.
`default_nettype none

module btnclk_checker
   import btnclk_pkg::*;
(
   input wire         clock,
   input wire         reset,
   input wire         rsp_valid,
   input wire         rsp_ready,
   input var rsp_type rsp_data
);

   // A stalled transaction stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the transaction was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // A long-press start always reports the flag set and the button held down.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == EV_LONG_START) |->
         rsp_data.long_press_active && rsp_data.debounced_level)
      else $error("long-press start without active flag and pressed level");

   // A long-press stop ends the gesture: flag cleared, count back to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == EV_LONG_STOP) |->
         !rsp_data.long_press_active && (rsp_data.click_count == 4'd0))
      else $error("long-press stop did not clear the gesture");

endmodule

bind button_click_longpress_detector btnclk_checker u_btnclk_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/sv/button_click_longpress_detector_tb.sv
// Self-checking testbench for button_click_longpress_detector: drives timestamped button
// samples on req, predicts every rsp transaction with a behavioral model and compares them.
// Depends on btnclk_pkg and the detector RTL.
`timescale 1ns / 1ps

module button_click_longpress_detector_tb;
   import btnclk_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Behavioral copy of the detector state and its registers.
   state_type   track_state = ST_IDLE;
   state_type   track_prev = ST_IDLE;
   logic [31:0] press_start = '0;
   logic [3:0]  click_total = '0;
   logic        level_db = 1'b0;
   logic        long_flag = 1'b0;
   cfg_type     cur_cfg = '{debounce_ms: 16'd50, long_press_ms: 16'd800,
                            click_window_ms: 16'd400, max_clicks: 4'd3};

   rsp_type     pending_events[$];
   logic [31:0] now_t = 32'd1000;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          error_count = 0;
   int          samples_driven = 0;
   int          results_checked = 0;
   int          settings_used = 1;
   int          cycle_count = 0;
   int          event_seen[8];

   button_click_longpress_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   function automatic void move_to(input state_type nxt);
      track_prev = track_state;
      track_state = nxt;
   endfunction

   function automatic void clear_gesture();
      track_state = ST_IDLE;
      track_prev = ST_IDLE;
      click_total = '0;
      press_start = '0;
   endfunction

   // Advances the model by one sample and returns the result it should produce.
   function automatic rsp_type predict_button_event(input req_type s);
      logic [31:0] elapsed;
      logic [2:0]  ev;
      rsp_type     r;
      elapsed = s.now_ms - press_start;
      ev = EV_NONE;
      case (track_state)
         ST_IDLE: begin
            if (s.active_level) begin
               move_to(ST_DOWN);
               press_start = s.now_ms;
               click_total = '0;
            end
         end
         ST_DOWN: begin
            if (!s.active_level) begin
               if (elapsed < cur_cfg.debounce_ms) begin
                  move_to(track_prev);
               end else begin
                  move_to(ST_UP);
                  level_db = 1'b0;
                  press_start = s.now_ms;
               end
            end else if (elapsed > cur_cfg.long_press_ms) begin
               ev = EV_LONG_START;
               long_flag = 1'b1;
               level_db = 1'b1;
               move_to(ST_LONG);
            end
         end
         ST_UP: begin
            if (s.active_level && elapsed < cur_cfg.debounce_ms) begin
               move_to(track_prev);
            end else if (elapsed >= cur_cfg.debounce_ms) begin
               if (click_total < CLICKS_MAX) click_total = click_total + 4'd1;
               level_db = s.active_level;
               move_to(ST_COUNT);
            end
         end
         ST_COUNT: begin
            if (s.active_level) begin
               move_to(ST_DOWN);
               press_start = s.now_ms;
            end else if (elapsed > cur_cfg.click_window_ms ||
                         click_total >= cur_cfg.max_clicks) begin
               if (click_total == 4'd1) ev = EV_CLICK;
               else if (click_total == 4'd2) ev = EV_DOUBLE;
               else ev = EV_MULTI;
            end
         end
         ST_LONG: begin
            if (!s.active_level) begin
               move_to(ST_LONG_END);
               press_start = s.now_ms;
            end
         end
         ST_LONG_END: begin
            if (s.active_level && elapsed < cur_cfg.debounce_ms) begin
               move_to(track_prev);
            end else if (elapsed >= cur_cfg.debounce_ms) begin
               ev = EV_LONG_STOP;
               long_flag = 1'b0;
               clear_gesture();
            end
         end
         default: clear_gesture();
      endcase
      r.event_res = ev;
      r.click_count = click_total;
      r.debounced_level = level_db;
      r.long_press_active = long_flag;
      if (ev inside {EV_CLICK, EV_DOUBLE, EV_MULTI}) clear_gesture();
      return r;
   endfunction

   // Predicts on every accepted sample and checks every accepted result.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) pending_events.push_back(predict_button_event(req_data));
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (pending_events.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result event=%0d count=%0d level=%0d long=%0d",
                        $time, rsp_data.event_res, rsp_data.click_count,
                        rsp_data.debounced_level, rsp_data.long_press_active);
            end else begin
               want = pending_events.pop_front();
               if (want.event_res !== rsp_data.event_res ||
                   want.click_count !== rsp_data.click_count ||
                   want.debounced_level !== rsp_data.debounced_level ||
                   want.long_press_active !== rsp_data.long_press_active) begin
                  error_count++;
                  $display({"%0t: mismatch expected event=%0d count=%0d level=%0d long=%0d,",
                            " actual event=%0d count=%0d level=%0d long=%0d"}, $time,
                           want.event_res, want.click_count, want.debounced_level,
                           want.long_press_active, rsp_data.event_res,
                           rsp_data.click_count, rsp_data.debounced_level,
                           rsp_data.long_press_active);
               end else begin
                  event_seen[want.event_res]++;
               end
            end
         end
      end
   end

   // Valid is left high after acceptance so back-to-back samples need no extra edge.
   task automatic send_sample(input logic lvl, input logic [31:0] stamp);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{active_level: lvl, now_ms: stamp};
      do @(posedge clock); while (!req_ready);
      samples_driven++;
   endtask

   // Holds the sender until every pending result has been delivered.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      csr_we <= 1'b1;
      csr_index <= REG_DEBOUNCE;
      csr_wdata <= c.debounce_ms;
      @(posedge clock);
      csr_index <= REG_LONG_PRESS;
      csr_wdata <= c.long_press_ms;
      @(posedge clock);
      csr_index <= REG_CLICK_WINDOW;
      csr_wdata <= c.click_window_ms;
      @(posedge clock);
      // Only the low nibble is meaningful; the rest is filled with noise.
      csr_index <= REG_MAX_CLICKS;
      csr_wdata <= {12'($urandom), c.max_clicks};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_cfg = c;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_ms(input int unsigned typical);
      case ($urandom_range(7, 0))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(typical, 1));
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.debounce_ms = pick_ms(20);
      c.long_press_ms = pick_ms(120);
      c.click_window_ms = pick_ms(80);
      c.max_clicks = 4'($urandom_range(15, 0));
      return c;
   endfunction

   // Keeps the button at one level for at least dur ms, sampled at random intervals.
   task automatic hold_level(input logic lvl, input int unsigned dur);
      logic [31:0] t0;
      t0 = now_t;
      do begin
         now_t += $urandom_range(dur / 4 + 1, 0);
         send_sample(lvl, now_t);
      end while (now_t - t0 < dur);
   endtask

   task automatic test_default_click();
      send_sample(1'b0, 32'd1000);
      send_sample(1'b1, 32'd1010);
      send_sample(1'b0, 32'd1040);  // bounce back to idle
      send_sample(1'b1, 32'd1050);
      send_sample(1'b0, 32'd1120);
      send_sample(1'b0, 32'd1180);
      send_sample(1'b0, 32'd1600);  // window expires, single click
   endtask

   task automatic test_long_press();
      send_sample(1'b1, 32'd2000);
      send_sample(1'b1, 32'd2900);
      send_sample(1'b0, 32'd3000);
      send_sample(1'b1, 32'd3010);  // bounce during the long-press release
      send_sample(1'b0, 32'd3020);
      send_sample(1'b0, 32'd3080);
   endtask

   task automatic test_extreme_settings();
      wait_idle();
      apply_config('{debounce_ms: 16'd0, long_press_ms: 16'hFFFF,
                     click_window_ms: 16'd0, max_clicks: 4'd0});
      // The press straddles the timestamp wrap.
      send_sample(1'b1, 32'hFFFF_FFF0);
      send_sample(1'b0, 32'd5);
      send_sample(1'b0, 32'd6);
      send_sample(1'b0, 32'd7);
      wait_idle();
      apply_config('{debounce_ms: 16'd0, long_press_ms: 16'hFFFF,
                     click_window_ms: 16'd0, max_clicks: 4'd2});
      send_sample(1'b1, 32'd10);
      send_sample(1'b0, 32'd11);
      send_sample(1'b1, 32'd12);
      send_sample(1'b1, 32'd13);
      send_sample(1'b0, 32'd14);
      send_sample(1'b0, 32'd15);
      send_sample(1'b0, 32'd16);
      wait_idle();
      apply_config('{debounce_ms: 16'hFFFF, long_press_ms: 16'd0,
                     click_window_ms: 16'hFFFF, max_clicks: 4'd15});
      send_sample(1'b1, 32'd100);
      send_sample(1'b1, 32'd101);
      send_sample(1'b0, 32'd102);
      send_sample(1'b0, 32'd103);
      send_sample(1'b0, 32'h0001_0100);
   endtask

   task automatic test_random_gestures(input int target, input int idle_pct, input int stall_pct);
      int unsigned deb, lng, win, n;
      int          phase_start;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      phase_start = samples_driven;
      deb = cur_cfg.debounce_ms;
      lng = cur_cfg.long_press_ms;
      win = cur_cfg.click_window_ms;
      now_t = $urandom();
      while (samples_driven - phase_start < target) begin
         case ($urandom_range(9, 0))
            0, 1, 2, 3, 4: begin
               n = $urandom_range(int'(cur_cfg.max_clicks) + 1, 1);
               repeat (n) begin
                  if (deb > 0 && $urandom_range(3, 0) == 0) begin
                     hold_level(1'b1, $urandom_range(deb - 1, 0));
                     hold_level(1'b0, $urandom_range(deb - 1, 0));
                  end
                  hold_level(1'b1, deb + $urandom_range(lng / 2, 0));
                  hold_level(1'b0, deb + $urandom_range(win, 0));
               end
               hold_level(1'b0, deb + win + 1);
            end
            5, 6: begin
               hold_level(1'b1, lng + deb + 1 + $urandom_range(deb, 0));
               if (deb > 0 && $urandom_range(1, 0) == 0) begin
                  hold_level(1'b0, $urandom_range(deb - 1, 0));
                  hold_level(1'b1, $urandom_range(deb, 0));
               end
               hold_level(1'b0, deb + win + 1);
            end
            7: begin
               repeat ($urandom_range(6, 2))
                  hold_level(1'($urandom_range(1, 0)), (deb > 0) ? $urandom_range(deb - 1, 0) : 0);
            end
            8: begin
               repeat (8) begin
                  now_t += $urandom_range(2 * deb + win + 2, 0);
                  send_sample(1'($urandom_range(1, 0)), now_t);
               end
            end
            default: begin
               if ($urandom_range(1, 0) == 0)
                  now_t = 32'hFFFF_FFFF - $urandom_range(deb + lng + win, 0);
               else
                  now_t = $urandom();
               // Now and then the sender stops until the pipeline has drained.
               if ($urandom_range(3, 0) == 0) wait_idle();
            end
         endcase
      end
   endtask

   task automatic finish_run();
      wait_idle();
      rsp_stall_pct = 0;
      repeat (8) @(posedge clock);
      if (pending_events.size() != 0) begin
         error_count += pending_events.size();
         $display("%0t: %0d results never arrived", $time, pending_events.size());
      end
      $display("Drove %0d samples under %0d register settings, checked %0d results.",
               samples_driven, settings_used, results_checked);
      $display("Events seen: click %0d, double %0d, multi %0d, long start %0d, long stop %0d.",
               event_seen[EV_CLICK], event_seen[EV_DOUBLE], event_seen[EV_MULTI],
               event_seen[EV_LONG_START], event_seen[EV_LONG_STOP]);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   endtask

   initial begin
      int idle_modes[4];
      int stall_modes[4];
      idle_modes = '{0, 57, 0, 33};
      stall_modes = '{0, 0, 57, 33};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_click();
      test_long_press();
      test_extreme_settings();
      // A phase runs until its target is reached; the last gesture usually overshoots it.
      for (int m = 0; m < 4; m++) begin
         repeat (3) begin
            wait_idle();
            apply_config(random_config());
            test_random_gestures(40, idle_modes[m], stall_modes[m]);
         end
      end
      finish_run();
   end

endmodule
